// ===== rtl/core/lcttl_pkg.sv =====
package lcttl_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths
    localparam int OPC_BITS = 2;
    localparam int TTL_BITS = 33;
    localparam int NOW_BITS = 32;
    // now + ttl spans -2^32 .. 2^33-2, so one more bit than ttl
    localparam int EXP_BITS = 34;
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OPC_BITS-1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Recency table update kinds
    typedef enum logic [1:0] {
        RK_NONE,
        RK_TOUCH,
        RK_REMOVE,
        RK_INSERT
    } rank_op_t;

    typedef struct packed {
        rank_op_t op;
        logic     clr_en;
    } rank_cmd_t;

endpackage

// ===== rtl/core/lru_cache_with_ttl_unit.sv =====
// Key/value table of ENTRIES slots with least-recently-used replacement and a
// per-entry time-to-live. Each input beat carries one operation in s_tuser (set,
// get, delete, or no-op) plus key, value, ttl and the current time in s_tdata;
// each beat yields exactly one result beat. A set makes its entry most recent
// and evicts the oldest entry once occupancy would pass capacity_limit (written
// through cfg_we/cfg_wdata, reset 16, values above ENTRIES act as ENTRIES; the
// user is to write it only while the unit is idle, and the unit does not enforce
// this). A ttl of -1 never expires; a get that finds an expired entry removes it
// and flags expired. Per item, one key comparator walks the entry RAM at one read
// per cycle in SCAN, SCAN_END finishes the last compare, EXEC applies the update
// and DONE presents the result. s_tready is high only between items. The table
// is empty after reset, with no clearing pass.
module lru_cache_with_ttl_unit
    import lcttl_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CAP_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // key, value, ttl, now (lowest first), zero pad
    input  logic [((KEY_BITS+VALUE_BITS+TTL_BITS+NOW_BITS+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic [OPC_BITS-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_value, evicted_key (lowest first), zero pad
    output logic [((VALUE_BITS+KEY_BITS+7)/8)*8-1:0] m_tdata,
    // found, expired, evicted (lowest first)
    output logic [2:0]          m_tuser
);

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int RANK_W   = IDX_W;
    localparam int OCC_W    = $clog2(ENTRIES + 1);
    localparam int LIM_W    = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;
    localparam int M_DATA_W = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;
    localparam int ENT_W    = KEY_BITS + VALUE_BITS + EXP_BITS + 1;
    localparam int VAL_LO   = KEY_BITS;
    localparam int TTL_LO   = KEY_BITS + VALUE_BITS;
    localparam int NOW_LO   = KEY_BITS + VALUE_BITS + TTL_BITS;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CAP_BITS-1:0]     cap_reg;
    logic [OCC_W-1:0]        occ_reg;

    // latched item
    opcode_t                 op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic [TTL_BITS-1:0]     ttl_reg;
    logic [NOW_BITS-1:0]     now_reg;

    // scan pipeline
    logic [IDX_W-1:0]        scan_reg;
    logic                    pipe_vld_reg;
    logic [IDX_W-1:0]        pipe_idx_reg;

    // scan captures
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [RANK_W-1:0]       hit_rank_reg;
    logic [VALUE_BITS-1:0]   hit_val_reg;
    logic [EXP_BITS-1:0]     hit_exp_reg;
    logic                    hit_never_reg;
    logic [IDX_W-1:0]        old_idx_reg;
    logic [KEY_BITS-1:0]     old_key_reg;
    logic [IDX_W-1:0]        sec_idx_reg;
    logic [KEY_BITS-1:0]     sec_key_reg;
    logic                    free_vld_reg;
    logic [IDX_W-1:0]        free_idx_reg;

    // result
    logic                    res_found_reg;
    logic [VALUE_BITS-1:0]   res_rval_reg;
    logic                    res_expd_reg;
    logic                    res_ev_reg;
    logic [KEY_BITS-1:0]     res_evk_reg;
    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;
    logic [2:0]              m_tuser_reg;

    logic                    s_beat;
    logic                    out_free;

    // entry RAM and recency table
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [ENT_W-1:0]        ram_rdata;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_val;
    logic [EXP_BITS-1:0]     rd_exp;
    logic                    rd_never;
    rank_cmd_t               rk_cmd;
    logic [IDX_W-1:0]        rk_slot;
    logic [RANK_W-1:0]       rk_ref;
    logic [IDX_W-1:0]        rk_clr_idx;
    logic [ENTRIES-1:0]      vld_vec;
    logic [RANK_W-1:0]       rd_rank;

    // scan compare
    logic                    p_valid;
    logic [OCC_W-1:0]        occ_m1;
    logic [OCC_W-1:0]        occ_m2;
    logic                    m_hit;
    logic                    m_old;
    logic                    m_sec;
    logic                    m_free;

    // decision
    logic [LIM_W-1:0]        occ_l;
    logic [LIM_W-1:0]        limit_l;
    logic                    new_never;
    logic [EXP_BITS-1:0]     new_exp;
    logic                    hit_stale;
    logic                    hit_oldest;
    logic                    occ_inc;
    logic                    occ_dec;
    logic                    ex_found;
    logic [VALUE_BITS-1:0]   ex_rval;
    logic                    ex_expd;
    logic                    ex_ev;
    logic [KEY_BITS-1:0]     ex_evk;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    lcttl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    lcttl_rank #(
        .ENTRIES (ENTRIES)
    ) u_rank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (rk_cmd),
        .slot     (rk_slot),
        .ref_rank (rk_ref),
        .clr_idx  (rk_clr_idx),
        .rd_idx   (pipe_idx_reg),
        .vld_vec  (vld_vec),
        .rd_rank  (rd_rank)
    );

    // entry word: {never, expiry, value, key}
    assign rd_key   = ram_rdata[KEY_BITS-1:0];
    assign rd_val   = ram_rdata[VAL_LO +: VALUE_BITS];
    assign rd_exp   = ram_rdata[TTL_LO +: EXP_BITS];
    assign rd_never = ram_rdata[ENT_W-1];

    // one entry compared per cycle: key match, oldest, second oldest, first free
    assign p_valid = vld_vec[pipe_idx_reg];
    assign occ_m1  = occ_reg - OCC_W'(1);
    assign occ_m2  = occ_reg - OCC_W'(2);
    assign m_hit   = pipe_vld_reg && p_valid && (rd_key == key_reg);
    assign m_old   = pipe_vld_reg && p_valid && (OCC_W'(rd_rank) == occ_m1);
    assign m_sec   = pipe_vld_reg && p_valid && (OCC_W'(rd_rank) == occ_m2);
    assign m_free  = pipe_vld_reg && !p_valid && !free_vld_reg;

    // effective capacity and new expiry
    assign occ_l     = LIM_W'(occ_reg);
    assign limit_l   = (LIM_W'(cap_reg) > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : LIM_W'(cap_reg);
    assign new_never = (ttl_reg == {TTL_BITS{1'b1}});
    assign new_exp   = new_never ? '0 :
        ({{(EXP_BITS-NOW_BITS){1'b0}}, now_reg} +
         {{(EXP_BITS-TTL_BITS){ttl_reg[TTL_BITS-1]}}, ttl_reg});
    assign hit_stale  = !hit_never_reg &&
        ($signed({{(EXP_BITS-NOW_BITS){1'b0}}, now_reg}) > $signed(hit_exp_reg));
    assign hit_oldest = (OCC_W'(hit_rank_reg) == occ_m1);
    assign ram_wdata  = {new_never, new_exp, val_reg, key_reg};

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: state_next = ST_EXEC;
            ST_EXEC:     state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // operation decode and table update, applied in the EXEC cycle
    always_comb begin
        ex_found   = 1'b0;
        ex_rval    = '0;
        ex_expd    = 1'b0;
        ex_ev      = 1'b0;
        ex_evk     = '0;
        rk_cmd     = '{op: RK_NONE, clr_en: 1'b0};
        rk_slot    = hit_idx_reg;
        rk_ref     = hit_rank_reg;
        rk_clr_idx = hit_idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = hit_idx_reg;
        occ_inc    = 1'b0;
        occ_dec    = 1'b0;
        if (state_reg == ST_EXEC) begin
            case (op_reg)
                OP_SET: begin
                    if (hit_reg) begin
                        // update in place; lowered capacity still evicts one
                        rk_cmd.op = RK_TOUCH;
                        ram_we    = 1'b1;
                        if (occ_l > limit_l) begin
                            ex_ev         = 1'b1;
                            rk_cmd.clr_en = 1'b1;
                            occ_dec       = 1'b1;
                            if (hit_oldest) begin
                                if (occ_reg == OCC_W'(1)) begin
                                    rk_clr_idx = hit_idx_reg;
                                    ex_evk     = key_reg;
                                end else begin
                                    rk_clr_idx = sec_idx_reg;
                                    ex_evk     = sec_key_reg;
                                end
                            end else begin
                                rk_clr_idx = old_idx_reg;
                                ex_evk     = old_key_reg;
                            end
                        end
                    end else if (occ_reg == '0 && limit_l == '0) begin
                        // zero capacity, empty table: new key bounces straight out
                        ex_ev  = 1'b1;
                        ex_evk = key_reg;
                    end else begin
                        rk_cmd.op = RK_INSERT;
                        ram_we    = 1'b1;
                        if (occ_l >= limit_l) begin
                            ex_ev         = 1'b1;
                            ex_evk        = old_key_reg;
                            rk_cmd.clr_en = 1'b1;
                            rk_clr_idx    = old_idx_reg;
                            rk_slot       = (free_vld_reg && free_idx_reg < old_idx_reg) ?
                                            free_idx_reg : old_idx_reg;
                        end else begin
                            rk_slot = free_idx_reg;
                            occ_inc = 1'b1;
                        end
                        ram_waddr = rk_slot;
                    end
                end
                OP_GET: begin
                    if (hit_reg) begin
                        if (hit_stale) begin
                            ex_expd       = 1'b1;
                            rk_cmd.op     = RK_REMOVE;
                            rk_cmd.clr_en = 1'b1;
                            occ_dec       = 1'b1;
                        end else begin
                            ex_found  = 1'b1;
                            ex_rval   = hit_val_reg;
                            rk_cmd.op = RK_TOUCH;
                        end
                    end
                end
                OP_DEL: begin
                    if (hit_reg) begin
                        rk_cmd.op     = RK_REMOVE;
                        rk_cmd.clr_en = 1'b1;
                        occ_dec       = 1'b1;
                    end
                end
                default: begin
                    ex_found = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            occ_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pipe_vld_reg <= (state_reg == ST_SCAN);
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (occ_inc) begin
                occ_reg <= occ_reg + OCC_W'(1);
            end else if (occ_dec) begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // item latch, scan counter and captures
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            op_reg       <= opcode_t'(s_tuser);
            key_reg      <= s_tdata[KEY_BITS-1:0];
            val_reg      <= s_tdata[VAL_LO +: VALUE_BITS];
            ttl_reg      <= s_tdata[TTL_LO +: TTL_BITS];
            now_reg      <= s_tdata[NOW_LO +: NOW_BITS];
            scan_reg     <= '0;
            hit_reg      <= 1'b0;
            free_vld_reg <= 1'b0;
        end else if (state_reg == ST_SCAN && scan_reg != IDX_W'(ENTRIES - 1)) begin
            scan_reg <= scan_reg + IDX_W'(1);
        end
        pipe_idx_reg <= scan_reg;
        if (m_hit) begin
            hit_reg       <= 1'b1;
            hit_idx_reg   <= pipe_idx_reg;
            hit_rank_reg  <= rd_rank;
            hit_val_reg   <= rd_val;
            hit_exp_reg   <= rd_exp;
            hit_never_reg <= rd_never;
        end
        if (m_old) begin
            old_idx_reg <= pipe_idx_reg;
            old_key_reg <= rd_key;
        end
        if (m_sec) begin
            sec_idx_reg <= pipe_idx_reg;
            sec_key_reg <= rd_key;
        end
        if (m_free) begin
            free_vld_reg <= 1'b1;
            free_idx_reg <= pipe_idx_reg;
        end
        if (state_reg == ST_EXEC) begin
            res_found_reg <= ex_found;
            res_rval_reg  <= ex_rval;
            res_expd_reg  <= ex_expd;
            res_ev_reg    <= ex_ev;
            res_evk_reg   <= ex_evk;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= M_DATA_W'({res_evk_reg, res_rval_reg});
            m_tuser_reg <= {res_ev_reg, res_expd_reg, res_found_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // occupancy tracks the number of live slots
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(vld_vec) == occ_reg)
        else $error("occupancy does not match live slot count");

    // a result appears only out of the DONE step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside DONE");

    // an insert never lands on a live slot unless that slot is being evicted
    a_insert_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && rk_cmd.op == RK_INSERT) |->
        (!vld_vec[rk_slot] || (rk_cmd.clr_en && rk_clr_idx == rk_slot)))
        else $error("insert overwrites a live entry");
`endif

endmodule

// ===== rtl/core/lcttl_ram.sv =====
module lcttl_ram
    import lcttl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lcttl_rank.sv =====
module lcttl_rank
    import lcttl_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rank_cmd_t                  cmd,
    input  logic [$clog2(ENTRIES)-1:0] slot,
    input  logic [$clog2(ENTRIES)-1:0] ref_rank,
    input  logic [$clog2(ENTRIES)-1:0] clr_idx,
    input  logic [$clog2(ENTRIES)-1:0] rd_idx,
    output logic [ENTRIES-1:0]         vld_vec,
    output logic [$clog2(ENTRIES)-1:0] rd_rank
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = IDX_W;

    logic [ENTRIES-1:0] vld_reg;
    logic [ENTRIES-1:0] vld_next;
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [ENTRIES-1:0] kill_vec;
    logic [ENTRIES-1:0] slot_vec;
    logic [ENTRIES-1:0] live_vec;

    // per-entry decode of the broadcast command
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            kill_vec[i] = cmd.clr_en && (clr_idx == IDX_W'(i));
            slot_vec[i] = (slot == IDX_W'(i));
            live_vec[i] = vld_reg[i] && !kill_vec[i];
        end
    end

    // each entry updates its own rank: touch and remove compare it against ref_rank, insert ages every live entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            vld_next[i]  = live_vec[i];
            rank_next[i] = rank_reg[i];
            case (cmd.op)
                RK_TOUCH: begin
                    if (slot_vec[i]) begin
                        rank_next[i] = '0;
                    end else if (live_vec[i] && rank_reg[i] < ref_rank) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                RK_REMOVE: begin
                    if (live_vec[i] && rank_reg[i] > ref_rank) begin
                        rank_next[i] = rank_reg[i] - RANK_W'(1);
                    end
                end
                RK_INSERT: begin
                    if (slot_vec[i]) begin
                        vld_next[i]  = 1'b1;
                        rank_next[i] = '0;
                    end else if (live_vec[i]) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                default: begin
                    rank_next[i] = rank_reg[i];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            rank_reg[i] <= rank_next[i];
        end
    end

    assign vld_vec = vld_reg;
    assign rd_rank = rank_reg[rd_idx];

endmodule

// ===== test/lru_cache_with_ttl_unit_tb.sv =====
`timescale 1ns / 1ps

module lru_cache_with_ttl_unit_tb;
    import lcttl_pkg::*;

    localparam int SLOTS       = DEF_ENTRIES;
    localparam int IN_W        = ((DEF_KEY_BITS + DEF_VALUE_BITS + TTL_BITS + NOW_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((DEF_VALUE_BITS + DEF_KEY_BITS + 7) / 8) * 8;
    localparam int KEY_POOL    = 20;
    localparam int STALL_LIMIT = 1000;
    localparam int DIR_ROWS    = 29;

    // ttl encodings of interest (33-bit two's complement)
    localparam logic [TTL_BITS-1:0] TTL_FOREVER = 33'h1_FFFF_FFFF;
    localparam logic [TTL_BITS-1:0] TTL_MINUS2  = 33'h1_FFFF_FFFE;
    localparam logic [TTL_BITS-1:0] TTL_MOST    = 33'h0_FFFF_FFFF;
    localparam logic [TTL_BITS-1:0] TTL_LEAST   = 33'h1_0000_0000;

    typedef struct packed {
        opcode_t                   op;
        logic [DEF_KEY_BITS-1:0]   key;
        logic [DEF_VALUE_BITS-1:0] val;
        logic [TTL_BITS-1:0]       ttl;
        logic [NOW_BITS-1:0]       now;
    } lookup_req_t;

    typedef struct packed {
        logic                      found;
        logic [DEF_VALUE_BITS-1:0] rd_val;
        logic                      expired;
        logic                      evicted;
        logic [DEF_KEY_BITS-1:0]   ev_key;
    } lookup_res_t;

    // A directed row either sends one beat or rewrites capacity (taken from val)
    typedef enum logic {
        ROW_ITEM,
        ROW_CAP
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        lookup_req_t req;
        logic        typed;
        lookup_res_t want;
    } dir_row_t;

    localparam lookup_res_t MISS    = '0;
    localparam lookup_res_t EXPIRED = '{1'b0, 32'h0, 1'b1, 1'b0, 32'h0};

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CAP_BITS-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;   // key, value, ttl, now (lowest first), zero pad
    logic [OPC_BITS-1:0] s_tuser;   // opcode
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;   // read_value, evicted_key (lowest first)
    logic [2:0]          m_tuser;   // found, expired, evicted (lowest first)

    // Shadow copy of the table
    logic                      slot_valid [SLOTS];
    logic [DEF_KEY_BITS-1:0]   slot_key   [SLOTS];
    logic [DEF_VALUE_BITS-1:0] slot_val   [SLOTS];
    longint                    slot_exp   [SLOTS];
    logic                      slot_never [SLOTS];
    int unsigned               slot_rank  [SLOTS];
    int unsigned               live_count;
    int unsigned               cap_limit;

    lookup_res_t             expected_lookups [$];
    logic [DEF_KEY_BITS-1:0] key_pool [KEY_POOL];
    logic [NOW_BITS-1:0]     clock_s;
    bit                      idle_on;
    int unsigned             mismatches;
    int unsigned             n_sent;
    int unsigned             n_hits;
    int unsigned             n_expired;
    int unsigned             n_evicted;
    int unsigned             n_settings;
    int unsigned             n_pauses;
    int unsigned             stall_cycles;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // empty table: misses and a no-op with every bit set
        '{ROW_ITEM, '{OP_GET, 32'h0, 32'h0, 33'h0, 32'h0}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_DEL, 32'hFFFF_FFFF, 32'h0, 33'h0, 32'h0}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TTL_FOREVER, 32'hFFFF_FFFF},
          1'b1, MISS},
        // never-expiring entry read at the end of time
        '{ROW_ITEM, '{OP_SET, 32'h0, 32'hFFFF_FFFF, TTL_FOREVER, 32'h0}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_GET, 32'h0, 32'h0, 33'h0, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0}},
        // ttl zero: live at now == expiry, gone one second later
        '{ROW_ITEM, '{OP_SET, 32'hFFFF_FFFF, 32'h0, 33'h0, 32'd100}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_GET, 32'hFFFF_FFFF, 32'h0, 33'h0, 32'd100}, 1'b1,
          '{1'b1, 32'h0, 1'b0, 1'b0, 32'h0}},
        '{ROW_ITEM, '{OP_GET, 32'hFFFF_FFFF, 32'h0, 33'h0, 32'd101}, 1'b1, EXPIRED},
        // negative ttl other than -1 lands in the past
        '{ROW_ITEM, '{OP_SET, 32'h5, 32'h55, TTL_MINUS2, 32'd10}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_GET, 32'h5, 32'h0, 33'h0, 32'd10}, 1'b1, EXPIRED},
        // largest expiry, then smallest
        '{ROW_ITEM, '{OP_SET, 32'h7, 32'hA5A5_A5A5, TTL_MOST, 32'hFFFF_FFFF}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_GET, 32'h7, 32'h0, 33'h0, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0}},
        '{ROW_ITEM, '{OP_SET, 32'h9, 32'h5A5A_5A5A, TTL_LEAST, 32'h0}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_GET, 32'h9, 32'h0, 33'h0, 32'h0}, 1'b1, EXPIRED},
        // update in place, delete, miss on the deleted key
        '{ROW_ITEM, '{OP_SET, 32'h0, 32'h1234_5678, 33'd3, 32'd50}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_DEL, 32'h0, 32'h0, 33'h0, 32'h0}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_GET, 32'h0, 32'h0, 33'h0, 32'd51}, 1'b1, MISS},
        '{ROW_ITEM, '{OP_DEL, 32'h7, 32'h0, 33'h0, 32'h0}, 1'b0, MISS},
        // capacity zero on an empty table pushes the new key straight out
        '{ROW_CAP, '{OP_NOP, 32'h0, 32'd0, 33'h0, 32'h0}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_SET, 32'h1234, 32'h1, TTL_FOREVER, 32'h0}, 1'b1,
          '{1'b0, 32'h0, 1'b0, 1'b1, 32'h1234}},
        '{ROW_ITEM, '{OP_GET, 32'h1234, 32'h0, 33'h0, 32'h0}, 1'b1, MISS},
        // capacity two: full table with a new key evicts the oldest
        '{ROW_CAP, '{OP_NOP, 32'h0, 32'd2, 33'h0, 32'h0}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_SET, 32'hA, 32'h10, TTL_FOREVER, 32'd5}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_SET, 32'hB, 32'h11, 33'd20, 32'd5}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_GET, 32'hA, 32'h0, 33'h0, 32'd6}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_SET, 32'hC, 32'h12, 33'd20, 32'd7}, 1'b0, MISS},
        // capacity dropped below occupancy: one eviction per set
        '{ROW_CAP, '{OP_NOP, 32'h0, 32'd1, 33'h0, 32'h0}, 1'b0, MISS},
        '{ROW_ITEM, '{OP_SET, 32'hD, 32'h13, TTL_FOREVER, 32'd8}, 1'b0, MISS},
        '{ROW_CAP, '{OP_NOP, 32'h0, 32'd31, 33'h0, 32'h0}, 1'b0, MISS}
    };

    lru_cache_with_ttl_unit #(
        .ENTRIES    (DEF_ENTRIES),
        .KEY_BITS   (DEF_KEY_BITS),
        .VALUE_BITS (DEF_VALUE_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Table shadow
    // ---------------------------------------------------------------
    function automatic int slot_of_key(input logic [DEF_KEY_BITS-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int oldest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && (best < 0 || slot_rank[i] > slot_rank[best]))
                best = i;
        return best;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (!slot_valid[i])
                return i;
        return -1;
    endfunction

    // make s most recent; younger entries age by one
    function automatic void promote(input int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void drop_slot(input int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] > slot_rank[s])
                slot_rank[i]--;
        slot_valid[s] = 1'b0;
        if (live_count > 0)
            live_count--;
    endfunction

    // Evict the least recent entry, if any, into r
    function automatic void evict_oldest(inout lookup_res_t r);
        int o;
        o = oldest_slot();
        if (o >= 0) begin
            r.evicted = 1'b1;
            r.ev_key  = slot_key[o];
            drop_slot(o);
        end
    endfunction

    function automatic lookup_res_t predict_lookup(input lookup_req_t it);
        lookup_res_t r;
        int          s;
        int unsigned lim;
        bit          never;
        longint      t_now;
        longint      t_exp;
        r     = '0;
        t_now = longint'(it.now);
        never = (it.ttl == TTL_FOREVER);
        t_exp = never ? 0 : t_now + longint'($signed(it.ttl));
        lim   = (cap_limit > SLOTS) ? SLOTS : cap_limit;
        s     = slot_of_key(it.key);
        case (it.op)
            OP_SET: begin
                if (s >= 0) begin
                    promote(s);
                end else if (live_count == 0 && lim == 0) begin
                    r.evicted = 1'b1;
                    r.ev_key  = it.key;
                end else begin
                    if (live_count >= SLOTS || live_count + 1 > lim)
                        evict_oldest(r);
                    s = free_slot();
                    if (s >= 0) begin
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i])
                                slot_rank[i]++;
                        slot_valid[s] = 1'b1;
                        slot_rank[s]  = 0;
                        live_count++;
                    end
                end
                if (s >= 0) begin
                    slot_key[s]   = it.key;
                    slot_val[s]   = it.val;
                    slot_exp[s]   = t_exp;
                    slot_never[s] = never;
                    if (!r.evicted && live_count > lim)
                        evict_oldest(r);
                end
            end
            OP_GET: begin
                if (s >= 0) begin
                    if (!slot_never[s] && t_now > slot_exp[s]) begin
                        r.expired = 1'b1;
                        drop_slot(s);
                    end else begin
                        r.found  = 1'b1;
                        r.rd_val = slot_val[s];
                        promote(s);
                    end
                end
            end
            OP_DEL: begin
                if (s >= 0)
                    drop_slot(s);
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_op(input lookup_req_t it, input bit typed, input lookup_res_t typed_res);
        lookup_res_t want;
        @(negedge aclk);
        if (idle_on && $urandom_range(99) < 34) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge aclk);
        end
        s_tdata  = IN_W'({it.now, it.ttl, it.val, it.key});
        s_tuser  = it.op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        want = predict_lookup(it);
        expected_lookups.push_back(typed ? typed_res : want);
        n_sent++;
    endtask

    // hold off until every result is back and the unit takes beats again
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_lookups.size() != 0 || !s_tready)
            @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        wait_drained();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = cap;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cap_limit = cap;
        n_settings++;
    endtask

    task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int unsigned n_items);
        lookup_req_t it;
        int unsigned pick;
        set_capacity(cap);
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom();
        clock_s = $urandom_range(1) ? $urandom() : $urandom_range(0, 5000);
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                it.op = OP_SET;
            else if (pick < 80)
                it.op = OP_GET;
            else if (pick < 95)
                it.op = OP_DEL;
            else
                it.op = OP_NOP;
            it.key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(KEY_POOL - 1)];
            it.val = $urandom();
            pick = $urandom_range(99);
            if (pick < 40)
                it.ttl = TTL_FOREVER;
            else if (pick < 75)
                it.ttl = 33'($urandom_range(0, 40));
            else if (pick < 85)
                it.ttl = TTL_FOREVER - 33'($urandom_range(1, 49));
            else
                it.ttl = {1'($urandom_range(1)), 32'($urandom())};
            // mostly a slowly advancing clock, now and then a jump anywhere
            if ($urandom_range(19) == 0) begin
                it.now = $urandom();
            end else begin
                it.now  = clock_s;
                clock_s = clock_s + $urandom_range(0, 3);
            end
            if ($urandom_range(199) == 0) begin
                wait_drained();
                n_pauses++;
            end
            send_op(it, 1'b0, MISS);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------
    always @(negedge aclk)
        m_tready <= !idle_on || ($urandom_range(99) >= 34);

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s at %0t: expected %h, got %h", what, $time, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        lookup_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lookups.size() == 0) begin
                note_mismatch("result beat with nothing pending", {29'b0, m_tuser}, 32'h0);
            end else begin
                want = expected_lookups.pop_front();
                if (m_tuser[0] !== want.found)
                    note_mismatch("found", {31'b0, m_tuser[0]}, {31'b0, want.found});
                if (m_tdata[31:0] !== want.rd_val)
                    note_mismatch("read_value", m_tdata[31:0], want.rd_val);
                if (m_tuser[1] !== want.expired)
                    note_mismatch("expired", {31'b0, m_tuser[1]}, {31'b0, want.expired});
                if (m_tuser[2] !== want.evicted)
                    note_mismatch("evicted", {31'b0, m_tuser[2]}, {31'b0, want.evicted});
                if (m_tdata[63:32] !== want.ev_key)
                    note_mismatch("evicted_key", m_tdata[63:32], want.ev_key);
            end
            n_hits    += (m_tuser[0] === 1'b1);
            n_expired += (m_tuser[1] === 1'b1);
            n_evicted += (m_tuser[2] === 1'b1);
        end
    end

    // watchdog: too long without a beat on either side
    always @(posedge aclk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_NOP;
        m_tready     = 1'b0;
        idle_on      = 1'b1;
        mismatches   = 0;
        n_sent       = 0;
        n_hits       = 0;
        n_expired    = 0;
        n_evicted    = 0;
        n_settings   = 0;
        n_pauses     = 0;
        stall_cycles = 0;
        live_count   = 0;
        cap_limit    = CAP_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CAP)
                set_capacity(dir_rows[r].req.val[CAP_BITS-1:0]);
            else
                send_op(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases across capacity settings; one phase runs without idling
        run_phase(5'd16, 220);
        run_phase(5'd3, 200);
        run_phase(5'd0, 80);
        run_phase(5'd1, 150);
        run_phase(5'd31, 220);
        run_phase(5'($urandom_range(0, 31)), 200);
        idle_on = 1'b0;
        run_phase(5'd5, 200);
        idle_on = 1'b1;
        run_phase(5'd16, 250);
        run_phase(5'd2, 200);
        run_phase(5'($urandom_range(4, 31)), 200);

        wait_drained();
        repeat (30) @(posedge aclk);

        $display("Ran %0d operations over %0d capacity settings with %0d mid-run drains.",
                 n_sent, n_settings, n_pauses);
        $display("Observed %0d hits, %0d expired lookups, %0d evictions.",
                 n_hits, n_expired, n_evicted);
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
